/* rtl/cbor_pkg.sv */
// ----------------------------------------------------------------------------
// cbor_pkg
// Shared types and constants for the call branch offset repatch block.
// ----------------------------------------------------------------------------
package cbor_pkg;

	typedef enum logic [1:0] {
		MODE_X86   = 2'd0,
		MODE_ARM   = 2'd1,
		MODE_THUMB = 2'd2,
		MODE_A64   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SIZE  = 2'd1,
		ST_FORM  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	localparam int AddrW  = 64;
	localparam int WordW  = 32;
	localparam int SizeW  = 4;
	localparam int InDataW  = 168;
	localparam int OutDataW = 32;

	localparam logic [7:0]  X86_CALL_OP  = 8'he8;
	localparam logic [31:0] ARM_BL_OP    = 32'heb000000;
	localparam logic [31:0] ARM_OP_MASK  = 32'hff000000;
	localparam logic [15:0] THUMB_MASK   = 16'hf800;
	localparam logic [15:0] THUMB_FIRST  = 16'hf000;
	localparam logic [15:0] THUMB_SECOND = 16'hd000;
	localparam logic [31:0] A64_OP_MASK  = 32'hfc000000;
	localparam logic [31:0] A64_BL_OP    = 32'h94000000;
	localparam logic [31:0] ARM_IMM_MASK = 32'h00ffffff;
	localparam logic [31:0] A64_IMM_MASK = 32'h03ffffff;
	localparam logic [15:0] THUMB_HI_MASK = 16'h03ff;
	localparam logic [15:0] THUMB_LO_MASK = 16'h07ff;

	localparam logic [SizeW-1:0] X86_MIN_SIZE = 4'd5;
	localparam logic [SizeW-1:0] RISC_SIZE    = 4'd4;

	localparam logic [AddrW-1:0] X86_PC_ADJ   = 64'd5;
	localparam logic [AddrW-1:0] ARM_PC_ADJ   = 64'd8;
	localparam logic [AddrW-1:0] THUMB_PC_ADJ = 64'd4;
	localparam logic [AddrW-1:0] A64_PC_ADJ   = 64'd0;

endpackage

/* rtl/call_branch_offset_repatch.sv */
// ----------------------------------------------------------------------------
// call_branch_offset_repatch
// Re-targets one direct call (x86 rel32, ARM32 BL, Thumb BL, AArch64 BL).
// ----------------------------------------------------------------------------
// Each transaction carries one call to re-target and yields one result: a
// status (ok, bad size, not a direct call, target out of range) and the new
// instruction word, or zero on any failure. The block is a three-stage
// pipeline: checks and PC adjust add, the 64-bit displacement subtract, then
// range check and re-encode. A new transaction is taken every cycle unless
// an output stall has backed the pipeline up to the input. Stalled stages
// hold, and empty stages fill, independently.
module call_branch_offset_repatch
	import cbor_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// insn_word [31:0], insn_size [35:32], call_address [99:36],
	// target_address [163:100], zero [167:164]
	input  logic [InDataW-1:0]  s_tdata,
	// opcode [1:0]
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// new_word [31:0]
	output logic [OutDataW-1:0] m_tdata,
	// status [1:0]
	output logic [1:0]          m_tuser
);

	logic [WordW-1:0] in_word;
	logic [SizeW-1:0] in_size;
	logic [AddrW-1:0] in_pc;
	logic [AddrW-1:0] in_tgt;
	mode_t            in_mode;

	assign in_word = s_tdata[31:0];
	assign in_size = s_tdata[35:32];
	assign in_pc   = s_tdata[99:36];
	assign in_tgt  = s_tdata[163:100];
	assign in_mode = mode_t'(s_tuser);

	logic rdy1, rdy2, rdy3;
	logic vld_s1, vld_s2, vld_s3;

	assign rdy3     = !vld_s3 || m_tready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign s_tready = rdy1;

	// Stage 1: size and form checks, PC adjust
	status_t          chk_st;
	logic [AddrW-1:0] chk_adj;
	logic [AddrW-1:0] chk_tgt;

	always_comb begin
		chk_st  = ST_OK;
		chk_adj = X86_PC_ADJ;
		chk_tgt = in_tgt;
		unique case (in_mode)
			MODE_X86: begin
				chk_adj = X86_PC_ADJ;
				if (in_size < X86_MIN_SIZE) begin
					chk_st = ST_SIZE;
				end else if (in_word[7:0] != X86_CALL_OP) begin
					chk_st = ST_FORM;
				end
			end
			MODE_ARM: begin
				chk_adj = ARM_PC_ADJ;
				if (in_size != RISC_SIZE) begin
					chk_st = ST_SIZE;
				end else if ((in_word & ARM_OP_MASK) != ARM_BL_OP) begin
					chk_st = ST_FORM;
				end
			end
			MODE_THUMB: begin
				chk_adj = THUMB_PC_ADJ;
				chk_tgt = {in_tgt[AddrW-1:1], 1'b0};
				if (in_size != RISC_SIZE) begin
					chk_st = ST_SIZE;
				end else if ((in_word[15:0] & THUMB_MASK) != THUMB_FIRST) begin
					chk_st = ST_FORM;
				end
			end
			MODE_A64: begin
				chk_adj = A64_PC_ADJ;
				if (in_size != RISC_SIZE) begin
					chk_st = ST_SIZE;
				end else if ((in_word & A64_OP_MASK) != A64_BL_OP) begin
					chk_st = ST_FORM;
				end
			end
			default: begin
				chk_st = ST_FORM;
			end
		endcase
	end

	mode_t            mode_s1, mode_s2;
	status_t          st_s1, st_s2;
	logic [WordW-1:0] word_s1, word_s2;
	logic [AddrW-1:0] tgt_s1, base_s1, disp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy1) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			mode_s1 <= in_mode;
			st_s1   <= chk_st;
			word_s1 <= in_word;
			tgt_s1  <= chk_tgt;
			base_s1 <= in_pc + chk_adj;
		end
	end

	// Stage 2: displacement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			mode_s2 <= mode_s1;
			st_s2   <= st_s1;
			word_s2 <= word_s1;
			disp_s2 <= tgt_s1 - base_s1;
		end
	end

	// Stage 3: range check and re-encode
	logic             in_range;
	logic [WordW-1:0] enc_word;
	logic             th_s, th_j1, th_j2;
	logic [15:0]      th_first, th_second;

	assign th_s      = disp_s2[24];
	assign th_j1     = ~(disp_s2[23] ^ th_s);
	assign th_j2     = ~(disp_s2[22] ^ th_s);
	assign th_first  = THUMB_FIRST | {5'd0, th_s, 10'd0}
		| ({6'd0, disp_s2[21:12]} & THUMB_HI_MASK);
	assign th_second = THUMB_SECOND | {2'd0, th_j1, 1'b0, th_j2, 11'd0}
		| ({5'd0, disp_s2[11:1]} & THUMB_LO_MASK);

	always_comb begin
		in_range = 1'b0;
		enc_word = '0;
		unique case (mode_s2)
			MODE_X86: begin
				in_range = (disp_s2[63:31] == '0) || (disp_s2[63:31] == '1);
				enc_word = disp_s2[31:0];
			end
			MODE_ARM: begin
				in_range = (disp_s2[63:25] == '0) || (disp_s2[63:25] == '1);
				enc_word = (word_s2 & ARM_OP_MASK) | (disp_s2[33:2] & ARM_IMM_MASK);
			end
			MODE_THUMB: begin
				in_range = (disp_s2[63:24] == '0) || (disp_s2[63:24] == '1);
				enc_word = {th_second, th_first};
			end
			MODE_A64: begin
				in_range = (disp_s2[63:27] == '0) || (disp_s2[63:27] == '1);
				enc_word = (word_s2 & A64_OP_MASK) | (disp_s2[33:2] & A64_IMM_MASK);
			end
			default: begin
				in_range = 1'b0;
			end
		endcase
	end

	status_t          st_s3;
	logic [WordW-1:0] nw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && vld_s2) begin
			if (st_s2 != ST_OK) begin
				st_s3 <= st_s2;
				nw_s3 <= '0;
			end else if (!in_range) begin
				st_s3 <= ST_RANGE;
				nw_s3 <= '0;
			end else begin
				st_s3 <= ST_OK;
				nw_s3 <= enc_word;
			end
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = nw_s3;
	assign m_tuser  = st_s3;

endmodule

/* sim/tb_call_branch_offset_repatch.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_call_branch_offset_repatch
// Self-checking bench for the call branch offset repatch block.
// Drives calls of all four instruction sets through the input stream, first
// a directed set at the displacement limits, bad sizes and foreign opcodes,
// then random calls that are mostly well formed with random operands. Each
// accepted call is predicted in the bench. Each result on the output stream
// is checked against the oldest prediction. Random gaps fall on both
// streams, and one long output hold-off backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_call_branch_offset_repatch;
	import cbor_pkg::*;

	localparam int RANDOM_CALLS = 1100;
	localparam int HOLD_CYCLES  = 160;
	localparam int IDLE_LIMIT   = 1000;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		status_t     status;
		logic [31:0] new_word;
	} repatch_t;

	class patch_scoreboard;
		repatch_t pending_patches[$];
		int       errors;
		int       mode_seen[4];
		int       status_seen[4];

		function bit fits(logic [63:0] d, int k);
			logic [63:0] half;
			half = 64'd1 << k;
			return (d + half) < (half << 1);
		endfunction

		function repatch_t retarget(mode_t mode, logic [31:0] word, logic [3:0] size,
				logic [63:0] pc, logic [63:0] tgt);
			repatch_t    r;
			logic [63:0] d;
			logic        s, j1, j2;
			logic [15:0] first, second;
			r.status   = ST_OK;
			r.new_word = '0;
			if (mode == MODE_X86) begin
				if (size < X86_MIN_SIZE) begin
					r.status = ST_SIZE;
				end else if (word[7:0] != X86_CALL_OP) begin
					r.status = ST_FORM;
				end else begin
					d = tgt - (pc + X86_PC_ADJ);
					if (!fits(d, 31)) r.status = ST_RANGE;
					else r.new_word = d[31:0];
				end
			end else if (size != RISC_SIZE) begin
				r.status = ST_SIZE;
			end else begin
				unique case (mode)
					MODE_ARM: begin
						if ((word & ARM_OP_MASK) != ARM_BL_OP) begin
							r.status = ST_FORM;
						end else begin
							d = tgt - (pc + ARM_PC_ADJ);
							if (!fits(d, 25)) r.status = ST_RANGE;
							else r.new_word = (word & ARM_OP_MASK) | {8'b0, d[25:2]};
						end
					end
					MODE_THUMB: begin
						if ((word[15:0] & THUMB_MASK) != THUMB_FIRST) begin
							r.status = ST_FORM;
						end else begin
							d = {tgt[63:1], 1'b0} - (pc + THUMB_PC_ADJ);
							if (!fits(d, 24)) begin
								r.status = ST_RANGE;
							end else begin
								s  = d[24];
								j1 = ~(d[23] ^ s);
								j2 = ~(d[22] ^ s);
								first  = THUMB_FIRST | {5'b0, s, d[21:12]};
								second = THUMB_SECOND | {2'b0, j1, 1'b0, j2, d[11:1]};
								r.new_word = {second, first};
							end
						end
					end
					default: begin
						if ((word & A64_OP_MASK) != A64_BL_OP) begin
							r.status = ST_FORM;
						end else begin
							d = tgt - (pc + A64_PC_ADJ);
							if (!fits(d, 27)) r.status = ST_RANGE;
							else r.new_word = (word & A64_OP_MASK) | {6'b0, d[27:2]};
						end
					end
				endcase
			end
			return r;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
		endtask

		function void note_call(mode_t mode, logic [31:0] word, logic [3:0] size,
				logic [63:0] pc, logic [63:0] tgt);
			mode_seen[mode]++;
			pending_patches.push_back(retarget(mode, word, size, pc, tgt));
		endfunction

		task check_patch(logic [1:0] status, logic [31:0] new_word);
			repatch_t exp;
			if (pending_patches.size() == 0) begin
				report($sformatf("unexpected result status %0d word %h",
					status, new_word));
				return;
			end
			exp = pending_patches.pop_front();
			status_seen[exp.status]++;
			if (status != exp.status)
				report($sformatf("status %0d, expected %0d", status, exp.status));
			if (new_word != exp.new_word)
				report($sformatf("new_word %h, expected %h", new_word, exp.new_word));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic [1:0]          m_tuser;

	patch_scoreboard sb;
	bit              sender_gapless;
	bit              held_off;
	int              n_results;
	int              idle_cycles;

	call_branch_offset_repatch i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap(bit gapless);
		int r;
		r = $urandom_range(0, 99);
		if (gapless || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_call(mode_t mode, logic [31:0] word, logic [3:0] size,
			logic [63:0] pc, logic [63:0] tgt);
		int gap;
		gap = pick_gap(sender_gapless);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, tgt, pc, size, word};
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		sb.note_call(mode, word, size, pc, tgt);
	endtask

	task automatic send_toward(mode_t mode, logic [31:0] word, logic [3:0] size,
			logic [63:0] pc, logic [63:0] disp);
		logic [63:0] adj;
		unique case (mode)
			MODE_X86:   adj = X86_PC_ADJ;
			MODE_ARM:   adj = ARM_PC_ADJ;
			MODE_THUMB: adj = THUMB_PC_ADJ;
			default:    adj = A64_PC_ADJ;
		endcase
		send_call(mode, word, size, pc, pc + adj + disp);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_patch(m_tuser, m_tdata);
			n_results++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without a transaction", idle_cycles);
			$display("[call_branch_offset_repatch] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int stall;
		m_tready <= 1'b0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_gap(n_results >= 600 && n_results < 700);
			if (!held_off && n_results >= 400) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held_off = 1'b1;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		mode_t       mode;
		logic [31:0] word;
		logic [3:0]  size;
		logic [63:0] pc, disp;
		int          reach, pick;
		sb = new();
		n_results = 0;
		idle_cycles = 0;
		sender_gapless = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pc = 64'h0000_7fff_0000_1000;
		send_toward(MODE_X86, 32'h123456e8, 4'd5, pc, (64'd1 << 31) - 64'd1);
		send_toward(MODE_X86, 32'h000000e8, 4'd15, pc, -(64'd1 << 31));
		send_toward(MODE_X86, 32'hffffffe8, 4'd5, pc, 64'd1 << 31);
		send_toward(MODE_X86, 32'h000000e8, 4'd6, pc, -(64'd1 << 31) - 64'd1);
		send_toward(MODE_X86, 32'h000000e8, 4'd4, pc, 64'd64);
		send_toward(MODE_X86, 32'h000000e8, 4'd0, pc, 64'd64);
		send_toward(MODE_X86, 32'hffffffe9, 4'd5, pc, 64'd64);
		send_toward(MODE_X86, 32'h000000e8, 4'd5, 64'hffff_ffff_ffff_fffd, 64'd100);
		send_toward(MODE_ARM, 32'heb000000, 4'd4, pc, (64'd1 << 25) - 64'd1);
		send_toward(MODE_ARM, 32'hebffffff, 4'd4, pc, -(64'd1 << 25));
		send_toward(MODE_ARM, 32'heb123456, 4'd4, pc, 64'd1 << 25);
		send_toward(MODE_ARM, 32'heb000000, 4'd8, pc, 64'd16);
		send_toward(MODE_ARM, 32'hea000000, 4'd4, pc, 64'd16);
		send_toward(MODE_ARM, 32'h00000000, 4'd3, pc, 64'd16);
		send_call(MODE_THUMB, 32'h0000f000, 4'd4, pc,
			(pc + 64'd4 + (64'd1 << 24) - 64'd2) | 64'd1);
		send_toward(MODE_THUMB, 32'hfffff7ff, 4'd4, pc, -(64'd1 << 24));
		send_toward(MODE_THUMB, 32'h0000f000, 4'd4, pc, 64'd1 << 24);
		send_toward(MODE_THUMB, 32'h0000f800, 4'd4, pc, 64'd32);
		send_toward(MODE_THUMB, 32'h0000f000, 4'd2, pc, 64'd32);
		send_toward(MODE_A64, 32'h97ffffff, 4'd4, pc, (64'd1 << 27) - 64'd1);
		send_toward(MODE_A64, 32'h94000000, 4'd4, pc, -(64'd1 << 27));
		send_toward(MODE_A64, 32'h94000000, 4'd4, pc, -(64'd1 << 27) - 64'd1);
		send_toward(MODE_A64, 32'h14000000, 4'd4, pc, 64'd8);
		send_call(MODE_A64, 32'h94000000, 4'd4, 64'd0, 64'hffff_ffff_ffff_ffff);
		send_call(MODE_X86, 32'h000000e8, 4'd5, 64'hffff_ffff_ffff_ffff, 64'd0);

		for (int i = 0; i < RANDOM_CALLS; i++) begin
			sender_gapless = (i >= 300 && i < 420) || (i >= 800 && i < 880);
			mode = mode_t'($urandom_range(0, 3));
			word = $urandom();
			if ($urandom_range(0, 99) < 85) begin
				unique case (mode)
					MODE_X86:   word[7:0]   = X86_CALL_OP;
					MODE_ARM:   word[31:24] = ARM_BL_OP[31:24];
					MODE_THUMB: word[15:11] = THUMB_FIRST[15:11];
					default:    word[31:26] = A64_BL_OP[31:26];
				endcase
			end
			if ($urandom_range(0, 99) < 85)
				size = (mode == MODE_X86) ? 4'($urandom_range(5, 15)) : RISC_SIZE;
			else
				size = 4'($urandom_range(0, 15));
			unique case (mode)
				MODE_X86:   reach = 31;
				MODE_ARM:   reach = 25;
				MODE_THUMB: reach = 24;
				default:    reach = 27;
			endcase
			pick = $urandom_range(0, 9);
			if (pick < 8) pc = {$urandom(), $urandom()};
			else if (pick == 8) pc = 64'($urandom_range(0, 64));
			else pc = ~64'($urandom_range(0, 64));
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				disp = {$urandom(), $urandom()};
				disp = $signed(disp << (63 - reach)) >>> (63 - reach);
			end else if (pick < 55) begin
				disp = $urandom_range(0, 1) ? (64'd1 << reach) : -(64'd1 << reach);
				disp = disp + 64'($urandom_range(0, 8)) - 64'd4;
			end else if (pick < 75) begin
				disp = 64'($urandom_range(0, 256)) - 64'd128;
			end
			if (pick < 75) send_toward(mode, word, size, pc, disp);
			else send_call(mode, word, size, pc, {$urandom(), $urandom()});
		end
		s_tvalid <= 1'b0;

		while (sb.pending_patches.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d calls: x86 %0d, arm %0d, thumb %0d, a64 %0d",
			sb.mode_seen.sum(), sb.mode_seen[MODE_X86], sb.mode_seen[MODE_ARM],
			sb.mode_seen[MODE_THUMB], sb.mode_seen[MODE_A64]);
		$display({"results ok %0d, bad size %0d, not a call %0d, out of range %0d;",
			" output held %0d cycles"},
			sb.status_seen[ST_OK], sb.status_seen[ST_SIZE], sb.status_seen[ST_FORM],
			sb.status_seen[ST_RANGE], HOLD_CYCLES);
		if (sb.errors == 0 && sb.pending_patches.size() == 0) begin
			$display("[call_branch_offset_repatch] OK");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("[call_branch_offset_repatch] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/cbor_pkg.sv
rtl/call_branch_offset_repatch.sv
sim/tb_call_branch_offset_repatch.sv
